// File: rtl/hlgbp_pkg.sv
// Shared types, constants and helpers for the hybrid local/gshare branch predictor.
// No dependencies; the top level and hlgbp_fifo import this package.
`default_nettype none

package hlgbp_pkg;

	// Stream payload widths, padded to whole bytes
	localparam int ADDR_W    = 64;
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 8;

	// Two-bit saturating counters
	localparam int           CTR_W          = 2;
	localparam logic [1:0]   CTR_MIN        = 2'd0;
	localparam logic [1:0]   CTR_WEAK_TAKEN = 2'd2;
	localparam logic [1:0]   CTR_MAX        = 2'd3;
	// Chooser at or above this value selects the local component
	localparam logic [1:0]   CHOOSE_LOCAL   = 2'd2;

	// Result queue: holds every item that is in flight or waiting
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = 2;
	localparam int RES_CNT_W = 3;

	typedef logic [CTR_W-1:0] ctr_t;

	// Declared highest bit first: buffer_hit lands in bit 0
	typedef struct packed {
		logic entry_replaced;
		logic used_local;
		logic prediction_correct;
		logic predicted_taken;
		logic buffer_hit;
	} result_t;

	localparam int RES_W = $bits(result_t);

	function automatic ctr_t sat_step(input ctr_t c, input logic up);
		ctr_t r;
		if (up) begin
			r = (c == CTR_MAX) ? CTR_MAX : ctr_t'(c + 2'd1);
		end else begin
			r = (c == CTR_MIN) ? CTR_MIN : ctr_t'(c - 2'd1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/hybrid_local_gshare_branch_predictor.sv
// Top level of the hybrid local/gshare (tournament) branch predictor.
// Depends on hlgbp_pkg, hlgbp_ram and hlgbp_fifo.
`default_nettype none

// Each input item is one resolved branch (address and outcome); each produces exactly one
// result item telling whether the target buffer hit, what was predicted before training,
// whether that was right, which component was chosen and whether a valid entry was evicted.
// The block takes one item per clock unless the sweep runs or the queue is full. An item passes
// a first stage, where the target-buffer entry is read, and a second, where both counter tables
// are read and everything is trained; its result is registered into the queue and offered on
// m_tvalid. Results wait in a four-deep queue, so the input keeps flowing while a result is not
// yet taken; outside the reset sweep, input stalls only when four items are outstanding.
// Back-to-back items that touch the same entry or counter see each other's updates through
// forwarding around the memories. After reset the block sweeps all tables to their reset values,
// one address per cycle, over max(BUFFER_ENTRIES, 2^LOCAL_HISTORY_BITS, 2^GLOBAL_HISTORY_BITS)
// addresses (4096 at the defaults) with s_tready low. BUFFER_ENTRIES must be a power of two.

module hybrid_local_gshare_branch_predictor #(
	parameter int BUFFER_ENTRIES      = 1024,
	parameter int LOCAL_HISTORY_BITS  = 12,
	parameter int GLOBAL_HISTORY_BITS = 10
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// [63:0] branch_address, [64] was_taken, [71:65] zero
	input  wire logic [hlgbp_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [0] buffer_hit, [1] predicted_taken, [2] prediction_correct,
	// [3] used_local, [4] entry_replaced, [7:5] zero
	output logic      [hlgbp_pkg::M_TDATA_W-1:0]  m_tdata
);
	import hlgbp_pkg::*;

	localparam int IB     = $clog2(BUFFER_ENTRIES);
	localparam int TW     = ADDR_W - IB;
	localparam int LW     = LOCAL_HISTORY_BITS;
	localparam int GW     = GLOBAL_HISTORY_BITS;
	localparam int LDEPTH = 1 << LW;
	localparam int GDEPTH = 1 << GW;
	localparam int XW     = (IB > GW) ? IB : GW;
	localparam int SW1    = (BUFFER_ENTRIES > LDEPTH) ? BUFFER_ENTRIES : LDEPTH;
	localparam int SWEEP  = (SW1 > GDEPTH) ? SW1 : GDEPTH;
	localparam int CW     = $clog2(SWEEP);

	typedef struct packed {
		logic          valid;
		logic [TW-1:0] tag;
		logic [LW-1:0] hist;
		logic [1:0]    chooser;
	} entry_t;

	localparam int EW = $bits(entry_t);

	// Input decode
	logic          acc;
	logic [IB-1:0] in_idx;
	logic [TW-1:0] in_tag;
	logic          in_taken;

	// Stage 1: entry lookup
	logic          v_s1;
	logic [IB-1:0] idx_s1;
	logic [TW-1:0] tag_s1;
	logic          taken_s1;
	entry_t        btb_rd;
	entry_t        ent_s1;
	logic          hit_s1;
	logic [GW-1:0] gi_s1;

	// Stage 2: counter read and training
	logic          v_s2;
	logic [IB-1:0] idx_s2;
	logic [TW-1:0] tag_s2;
	logic          taken_s2;
	logic          hit_s2;
	entry_t        ent_s2;
	logic [GW-1:0] gi_s2;
	ctr_t          l_rdata;
	ctr_t          g_rdata;
	ctr_t          lc;
	ctr_t          gc;
	logic          p_local;
	logic          p_gshare;
	logic          use_local;
	logic          pred;
	logic [1:0]    ch_new;
	entry_t        ent_new;
	logic          btb_we_s2;
	logic          lwe_s2;
	logic [LW-1:0] l_waddr_s2;
	ctr_t          l_wdata_s2;
	logic          gwe_s2;
	logic [GW-1:0] g_waddr_s2;
	ctr_t          g_wdata_s2;
	logic [GW-1:0] ghist_next;
	logic          replaced;
	result_t       res_s2;

	// Write-forwarding copies of the last update to each memory
	logic          btbw_v_q;
	logic [IB-1:0] btbw_idx_q;
	entry_t        btbw_data_q;
	logic          lw_v_q;
	logic [LW-1:0] lw_idx_q;
	ctr_t          lw_data_q;
	logic          gw_v_q;
	logic [GW-1:0] gw_idx_q;
	ctr_t          gw_data_q;

	logic [GW-1:0]        ghist_q;
	logic                 clearing_q;
	logic [CW-1:0]        clr_idx_q;
	logic [RES_CNT_W-1:0] out_cnt_q;

	// Memory ports
	logic          btb_we;
	logic [IB-1:0] btb_waddr;
	entry_t        btb_wdata;
	logic [EW-1:0] btb_rdata_raw;
	logic          l_we;
	logic [LW-1:0] l_waddr;
	ctr_t          l_wdata;
	logic          g_we;
	logic [GW-1:0] g_waddr;
	ctr_t          g_wdata;

	result_t       out_res;
	logic          out_valid;

	// ------------------------------------------------------------------
	// Input side: take an item when the sweep is done and the queue has room
	// ------------------------------------------------------------------
	assign in_idx   = s_tdata[IB-1:0];
	assign in_tag   = s_tdata[ADDR_W-1:IB];
	assign in_taken = s_tdata[ADDR_W];
	assign s_tready = !clearing_q && (out_cnt_q < RES_CNT_W'(RES_DEPTH));
	assign acc      = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// Stage 1: resolve the entry, newest update first
	// ------------------------------------------------------------------
	assign btb_rd = btb_rdata_raw;

	always_comb begin
		if (btb_we_s2 && (idx_s2 == idx_s1)) begin
			ent_s1 = ent_new;
		end else if (btbw_v_q && (btbw_idx_q == idx_s1)) begin
			ent_s1 = btbw_data_q;
		end else begin
			ent_s1 = btb_rd;
		end
		hit_s1 = ent_s1.valid && (ent_s1.tag == tag_s1);
		// Global history as left behind by the item ahead
		gi_s1  = GW'(XW'(idx_s1) ^ XW'(ghist_next));
	end

	// ------------------------------------------------------------------
	// Stage 2: predict, then train counters, histories and chooser
	// ------------------------------------------------------------------
	always_comb begin
		lc = (lw_v_q && (lw_idx_q == ent_s2.hist)) ? lw_data_q : l_rdata;
		gc = (gw_v_q && (gw_idx_q == gi_s2))       ? gw_data_q : g_rdata;

		p_local   = (lc >= CTR_WEAK_TAKEN);
		p_gshare  = (gc >= CTR_WEAK_TAKEN);
		use_local = hit_s2 && (ent_s2.chooser >= CHOOSE_LOCAL);
		pred      = hit_s2 && (use_local ? p_local : p_gshare);

		// Move toward the component that alone was right
		ch_new = ent_s2.chooser;
		if (p_local != p_gshare) begin
			ch_new = sat_step(ent_s2.chooser, p_local == taken_s2);
		end

		ent_new    = ent_s2;
		btb_we_s2  = 1'b0;
		lwe_s2     = 1'b0;
		l_waddr_s2 = ent_s2.hist;
		l_wdata_s2 = CTR_WEAK_TAKEN;
		gwe_s2     = 1'b0;
		g_waddr_s2 = gi_s2;
		g_wdata_s2 = CTR_WEAK_TAKEN;
		ghist_next = ghist_q;
		replaced   = 1'b0;

		if (v_s2 && hit_s2) begin
			btb_we_s2       = 1'b1;
			ent_new.hist    = {ent_s2.hist[LW-2:0], taken_s2};
			ent_new.chooser = ch_new;
			lwe_s2          = 1'b1;
			l_wdata_s2      = sat_step(lc, taken_s2);
			gwe_s2          = 1'b1;
			g_wdata_s2      = sat_step(gc, taken_s2);
			ghist_next      = {ghist_q[GW-2:0], taken_s2};
		end else if (v_s2 && taken_s2) begin
			// Allocate; shift a taken bit into the old history, keep the chooser, seed both tables weak taken
			replaced      = ent_s2.valid;
			btb_we_s2     = 1'b1;
			ent_new.valid = 1'b1;
			ent_new.tag   = tag_s2;
			ent_new.hist  = {ent_s2.hist[LW-2:0], 1'b1};
			lwe_s2        = 1'b1;
			l_waddr_s2    = ent_new.hist;
			gwe_s2        = 1'b1;
			ghist_next    = {ghist_q[GW-2:0], 1'b1};
			g_waddr_s2    = GW'(XW'(idx_s2) ^ XW'(ghist_next));
		end

		res_s2.buffer_hit         = hit_s2;
		res_s2.predicted_taken    = pred;
		res_s2.prediction_correct = (pred == taken_s2);
		res_s2.used_local         = use_local;
		res_s2.entry_replaced     = replaced;
	end

	// ------------------------------------------------------------------
	// Memory port selection: the reset sweep owns the write ports
	// ------------------------------------------------------------------
	always_comb begin
		if (clearing_q) begin
			btb_we    = ({1'b0, clr_idx_q} < (CW+1)'(BUFFER_ENTRIES));
			btb_waddr = clr_idx_q[IB-1:0];
			btb_wdata = '0;
			l_we      = ({1'b0, clr_idx_q} < (CW+1)'(LDEPTH));
			l_waddr   = clr_idx_q[LW-1:0];
			l_wdata   = CTR_WEAK_TAKEN;
			g_we      = ({1'b0, clr_idx_q} < (CW+1)'(GDEPTH));
			g_waddr   = clr_idx_q[GW-1:0];
			g_wdata   = CTR_WEAK_TAKEN;
		end else begin
			btb_we    = btb_we_s2;
			btb_waddr = idx_s2;
			btb_wdata = ent_new;
			l_we      = lwe_s2;
			l_waddr   = l_waddr_s2;
			l_wdata   = l_wdata_s2;
			g_we      = gwe_s2;
			g_waddr   = g_waddr_s2;
			g_wdata   = g_wdata_s2;
		end
	end

	hlgbp_ram #(
		.DEPTH (BUFFER_ENTRIES),
		.WIDTH (EW)
	) u_btb (
		.clk   (clk),
		.we    (btb_we),
		.waddr (btb_waddr),
		.wdata (btb_wdata),
		.raddr (in_idx),
		.rdata (btb_rdata_raw)
	);

	hlgbp_ram #(
		.DEPTH (LDEPTH),
		.WIDTH (CTR_W)
	) u_local_ctr (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (ent_s1.hist),
		.rdata (l_rdata)
	);

	hlgbp_ram #(
		.DEPTH (GDEPTH),
		.WIDTH (CTR_W)
	) u_global_ctr (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_waddr),
		.wdata (g_wdata),
		.raddr (gi_s1),
		.rdata (g_rdata)
	);

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			btbw_v_q   <= 1'b0;
			lw_v_q     <= 1'b0;
			gw_v_q     <= 1'b0;
			ghist_q    <= '0;
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
			out_cnt_q  <= '0;
		end else begin
			v_s1     <= acc;
			v_s2     <= v_s1;
			// Remember this cycle's updates for the reads that just missed them
			btbw_v_q <= btb_we_s2;
			lw_v_q   <= lwe_s2;
			gw_v_q   <= gwe_s2;
			ghist_q  <= ghist_next;
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == CW'(SWEEP - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			// Count items accepted but not yet delivered
			case ({acc, m_tvalid && m_tready})
				2'b10:   out_cnt_q <= out_cnt_q + 1'b1;
				2'b01:   out_cnt_q <= out_cnt_q - 1'b1;
				default: out_cnt_q <= out_cnt_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		idx_s1      <= in_idx;
		tag_s1      <= in_tag;
		taken_s1    <= in_taken;

		idx_s2      <= idx_s1;
		tag_s2      <= tag_s1;
		taken_s2    <= taken_s1;
		hit_s2      <= hit_s1;
		ent_s2      <= ent_s1;
		gi_s2       <= gi_s1;

		btbw_idx_q  <= idx_s2;
		btbw_data_q <= ent_new;
		lw_idx_q    <= l_waddr_s2;
		lw_data_q   <= l_wdata_s2;
		gw_idx_q    <= g_waddr_s2;
		gw_data_q   <= g_wdata_s2;
	end

	// ------------------------------------------------------------------
	// Output side: hold results until the consumer takes them
	// ------------------------------------------------------------------
	hlgbp_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s2),
		.push_data (res_s2),
		.pop       (m_tready),
		.out_valid (out_valid),
		.out_data  (out_res)
	);

	assign m_tvalid = out_valid;
	assign m_tdata  = {(M_TDATA_W - RES_W)'(0), out_res};

endmodule

`default_nettype wire

// File: rtl/hlgbp_ram.sv
// Simple dual-port memory: one write port, one read port with registered data.
// Read during a write to the same address returns the old contents. No dependencies.
`default_nettype none

module hlgbp_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/hlgbp_fifo.sv
// Small result queue in front of the output stream.
// Depends on hlgbp_pkg for result_t and the queue sizes.
`default_nettype none

module hlgbp_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire hlgbp_pkg::result_t push_data,
	input  wire logic               pop,
	output logic                    out_valid,
	output hlgbp_pkg::result_t      out_data
);
	import hlgbp_pkg::*;

	result_t                slot_q [RES_DEPTH];
	logic [RES_PTR_W-1:0]   wr_ptr_q;
	logic [RES_PTR_W-1:0]   rd_ptr_q;
	logic [RES_CNT_W-1:0]   count_q;

	assign out_valid = (count_q != '0);
	assign out_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && out_valid) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop && out_valid})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire
